>>> src/rational_arith_unit_core_defines.svh
// Assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Opcodes and shared types for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Command and status between sequencer and divider
  typedef struct packed {
    logic start;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

>>> src/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle, 64-bit unsigned operands.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::div_cmd_t cmd,
  input  logic [63:0]       dividend,
  input  logic [63:0]       divisor,
  output rau_pkg::div_sts_t sts,
  output logic [63:0]       quot,
  output logic [63:0]       rem
);
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d;
  logic [64:0] r_sh;
  logic [64:0] r_sub;

  // Shift in next dividend bit and trial subtract
  assign r_sh  = {r, q[63]};
  assign r_sub = r_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        if (!r_sub[64]) begin
          r <= r_sub[63:0];
          q <= {q[62:0], 1'b1};
        end else begin
          r <= r_sh[63:0];
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quot     = q;
  assign rem      = r;
endmodule

>>> src/rational_arith_unit_core.sv
// Sequence: the multiply steps, then one divider run per Euclid remainder step,
// then the two divisions by the gcd before out_valid; a zero result goes to the
// output state straight after the multiply steps.
// Throughput: one transaction at a time; the next is accepted once the result leaves.
// Reset: rst synchronous active high clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Fraction add/sub/mul/div with gcd reduction and compare flags.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_core_defines.svh"
module rational_arith_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic signed [31:0]  a_num,
  input  logic [30:0]         a_den,
  input  logic signed [31:0]  b_num,
  input  logic [30:0]         b_den,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  res_num,
  output logic [62:0]         res_den,
  output logic                a_less,
  output logic                a_equal
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_DVN  = 3'd3;
  localparam logic [2:0] S_DVD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam int DW = OPERAND_WIDTH - 1;

  logic [2:0]         state;
  logic [1:0]         mstep;
  logic [1:0]         op;
  logic signed [32:0] an;
  logic signed [32:0] ad;
  logic signed [32:0] bn;
  logic signed [32:0] bd;
  logic signed [63:0] p0;
  logic signed [63:0] p1;
  logic signed [63:0] pm;
  logic signed [63:0] rd;
  logic [63:0]        gp;
  logic [63:0]        gq;
  logic [63:0]        nm;
  logic               neg;
  logic               wait_div;
  logic signed [32:0] mx;
  logic signed [32:0] my;
  logic signed [65:0] prod;
  logic signed [63:0] rn;
  rau_pkg::div_cmd_t  dcmd;
  rau_pkg::div_sts_t  dsts;
  logic [63:0]        ddvd;
  logic [63:0]        ddvs;
  logic [63:0]        dq;
  logic [63:0]        dr;

  assign in_stall = (state != S_IDLE);

  // Shared multiplier operand select: cross terms, a*b numerators, denominator
  always_comb begin
    mx = an;
    my = bd;
    case (mstep)
      2'd0: begin mx = an; my = bd; end
      2'd1: begin mx = bn; my = ad; end
      2'd2: begin mx = an; my = bn; end
      default: begin mx = ad; my = (op == rau_pkg::OP_DIV) ? bn : bd; end
    endcase
  end
  assign prod = mx * my;

  always_comb begin
    case (op)
      rau_pkg::OP_ADD: rn = p0 + p1;
      rau_pkg::OP_SUB: rn = p0 - p1;
      rau_pkg::OP_MUL: rn = pm;
      default:         rn = p0;
    endcase
  end

  rau_div u_div (
    .clk(clk), .rst(rst), .cmd(dcmd), .dividend(ddvd), .divisor(ddvs),
    .sts(dsts), .quot(dq), .rem(dr)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dcmd      <= '0;
      wait_div  <= 1'b0;
      mstep     <= '0;
    end else begin
      dcmd <= '0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= req_type;
            an      <= 33'(signed'(a_num[OPERAND_WIDTH-1:0]));
            bn      <= 33'(signed'(b_num[OPERAND_WIDTH-1:0]));
            ad      <= {{(33-DW){1'b0}}, a_den[DW-1:0]};
            bd      <= {{(33-DW){1'b0}}, b_den[DW-1:0]};
            a_equal <= (a_num[OPERAND_WIDTH-1:0] == b_num[OPERAND_WIDTH-1:0]) &&
                       (a_den[DW-1:0] == b_den[DW-1:0]);
            mstep   <= 2'd0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          if (mstep == 2'd0) p0 <= prod[63:0];
          if (mstep == 2'd1) p1 <= prod[63:0];
          if (mstep == 2'd2) pm <= prod[63:0];
          if (mstep == 2'd3) begin
            rd <= prod[63:0];
            a_less <= (p0 < p1);
            if (rn == 0 || prod[63:0] == 0) begin
              res_num   <= '0;
              res_den   <= 63'd1;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              neg   <= rn[63] ^ prod[63];
              nm    <= rn[63] ? -rn : rn;
              gp    <= rn[63] ? 64'(-rn) : 64'(rn);
              gq    <= prod[63] ? 64'(-prod[63:0]) : prod[63:0];
              wait_div <= 1'b0;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          // Euclid step: p, q <- q, p mod q
          if (!wait_div) begin
            if (gq == 0) begin
              ddvd     <= nm;
              ddvs     <= gp;
              dcmd.start <= 1'b1;
              wait_div <= 1'b1;
              state    <= S_DVN;
            end else begin
              ddvd     <= gp;
              ddvs     <= gq;
              dcmd.start <= 1'b1;
              wait_div <= 1'b1;
            end
          end else if (dsts.done) begin
            gp       <= gq;
            gq       <= dr;
            wait_div <= 1'b0;
          end
        end
        S_DVN: begin
          if (dsts.done) begin
            res_num    <= neg ? -dq : dq;
            ddvd       <= rd[63] ? 64'(-rd) : 64'(rd);
            ddvs       <= gp;
            dcmd.start <= 1'b1;
            state      <= S_DVD;
          end
        end
        S_DVD: begin
          if (dsts.done) begin
            res_den   <= dq[62:0];
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAU_ASSERT_IMP(a_valid_out, out_valid, state == S_OUT, "out_valid outside output state")
  `RAU_ASSERT_IMP(a_den_pos, out_valid, res_den != 63'd0, "zero result denominator")
  `RAU_ASSERT_NEXT(a_start_busy, dcmd.start, dsts.busy, "divider did not start")
  `RAU_ASSERT_IMP(a_stall_busy, dsts.busy, in_stall, "accepting while dividing")
endmodule
